### rtl/core/bba_pkg.sv
// Shared constants, codes and types of the buddy block allocator.
`default_nettype none
package bba_pkg;

    localparam int DEF_REGION_ORDER = 14;
    localparam int DEF_REGIONS      = 4;
    localparam int DEF_HEADER_BYTES = 4;

    // Smallest block is one 8-byte granule.
    localparam int MIN_ORDER = 3;
    localparam int WANT_W    = 5;
    localparam int NEED_W    = 17;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_TOO_BIG  = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SPLIT,
        S_TAKE,
        S_FCHK_RD,
        S_FCHK_EV,
        S_MRG_RD,
        S_MRG_EV,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

### rtl/core/bba_ifs.sv
// Request and response channel interfaces of the buddy block allocator.
`default_nettype none
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] request_bytes;
    logic [15:0] free_address;

    modport source (output valid, op, request_bytes, free_address, input ready);
    modport sink (input valid, op, request_bytes, free_address, output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] address;
    logic [3:0]  block_order;

    modport source (output valid, status, address, block_order, input ready);
    modport sink (input valid, status, address, block_order, output ready);
endinterface
`default_nettype wire

### rtl/core/bba_hdr_mem.sv
// Block header memory: one write port, one registered read port.
`default_nettype none
module bba_hdr_mem #(
    parameter int DEPTH = 8192,
    parameter int AWID  = 13,
    parameter int DWID  = 5
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AWID-1:0] waddr,
    input  wire logic [DWID-1:0] wdata,
    input  wire logic [AWID-1:0] raddr,
    output logic      [DWID-1:0] rdata
);

    logic [DWID-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/core/buddy_block_allocator.sv
// Buddy block allocator: a single header memory walked by a small sequencer.
// An allocate sizes the request, reads and evaluates each header visited in the
// scan and writes one header per split; a free checks its header, then reads
// the buddy at each merge level. Every step is bounded by the one header memory
// port. After reset a clearing pass writes all REGIONS << (REGION_ORDER-3)
// headers (8192 by default) before the first item is taken.
`default_nettype none
module buddy_block_allocator #(
    parameter int REGION_ORDER = bba_pkg::DEF_REGION_ORDER,
    parameter int REGIONS      = bba_pkg::DEF_REGIONS,
    parameter int HEADER_BYTES = bba_pkg::DEF_HEADER_BYTES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bba_req_if.sink    req,
    bba_rsp_if.source  rsp
);

    localparam int RW    = $clog2(REGIONS + 1);
    localparam int AW    = REGION_ORDER + $clog2(REGIONS);
    localparam int PW    = AW + 1;
    localparam int GW    = AW - bba_pkg::MIN_ORDER;
    localparam int DEPTH = REGIONS << (REGION_ORDER - bba_pkg::MIN_ORDER);
    localparam int OW    = $clog2(REGION_ORDER + 1);
    localparam int HW    = OW + 1;
    localparam logic [31:0] ARENA = 32'(REGIONS) << REGION_ORDER;

    bba_pkg::state_t state_reg, state_next;

    logic [GW:0]                  clr_reg, clr_next;
    logic [bba_pkg::NEED_W-1:0]   need_reg, need_next;
    logic [bba_pkg::WANT_W-1:0]   want_reg, want_next;
    logic [PW-1:0]                cur_reg, cur_next;
    logic [RW-1:0]                region_reg, region_next;
    logic [OW-1:0]                ord_reg, ord_next;
    logic [16:0]                  fstart_reg, fstart_next;
    bba_pkg::status_t             pst_reg, pst_next;
    logic [15:0]                  paddr_reg, paddr_next;
    logic [3:0]                   pord_reg, pord_next;
    logic                         rvalid_reg, rvalid_next;
    logic [1:0]                   rst_reg, rst_next;
    logic [15:0]                  raddr_reg, raddr_next;
    logic [3:0]                   rord_reg, rord_next;

    logic          we;
    logic [GW-1:0] waddr, raddr;
    logic [HW-1:0] wdata, rdata;

    logic [31:0]   fstart32;
    logic [PW-1:0] size, base, stop, bud, split_at, mrg_base;
    logic [OW-1:0] ho, o_dec;
    logic          hused;
    logic [31:0]   asum;

    bba_hdr_mem #(.DEPTH(DEPTH), .AWID(GW), .DWID(HW)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign fstart32 = 32'(fstart_reg);
    assign size     = PW'(1) << want_reg;
    assign base     = PW'(region_reg) << REGION_ORDER;
    assign stop     = base + (PW'(1) << REGION_ORDER) - size;
    assign bud      = cur_reg ^ (PW'(1) << ord_reg);
    assign mrg_base = cur_reg & bud;
    assign o_dec    = ord_reg - OW'(1);
    assign split_at = cur_reg + (PW'(1) << o_dec);
    assign ho       = rdata[OW-1:0];
    assign hused    = rdata[HW-1];
    assign asum     = 32'(cur_reg) + 32'(HEADER_BYTES);

    assign req.ready       = (state_reg == bba_pkg::S_IDLE);
    assign rsp.valid       = rvalid_reg;
    assign rsp.status      = rst_reg;
    assign rsp.address     = raddr_reg;
    assign rsp.block_order = rord_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bba_pkg::S_CLEAR;
            clr_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg   <= need_next;
        want_reg   <= want_next;
        cur_reg    <= cur_next;
        region_reg <= region_next;
        ord_reg    <= ord_next;
        fstart_reg <= fstart_next;
        pst_reg    <= pst_next;
        paddr_reg  <= paddr_next;
        pord_reg   <= pord_next;
        rst_reg    <= rst_next;
        raddr_reg  <= raddr_next;
        rord_reg   <= rord_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        need_next   = need_reg;
        want_next   = want_reg;
        cur_next    = cur_reg;
        region_next = region_reg;
        ord_next    = ord_reg;
        fstart_next = fstart_reg;
        pst_next    = pst_reg;
        paddr_next  = paddr_reg;
        pord_next   = pord_reg;
        rvalid_next = rvalid_reg;
        rst_next    = rst_reg;
        raddr_next  = raddr_reg;
        rord_next   = rord_reg;
        we          = 1'b0;
        waddr       = cur_reg[AW-1:bba_pkg::MIN_ORDER];
        wdata       = '0;
        raddr       = cur_reg[AW-1:bba_pkg::MIN_ORDER];

        if (rvalid_reg && rsp.ready)
        begin
            rvalid_next = 1'b0;
        end

        unique case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                // Region starts get a whole free region, all other headers zero.
                we    = 1'b1;
                waddr = clr_reg[GW-1:0];
                if (clr_reg[REGION_ORDER-bba_pkg::MIN_ORDER-1:0] == '0)
                begin
                    wdata = {1'b0, OW'(REGION_ORDER)};
                end
                clr_next = clr_reg + (GW+1)'(1);
                if (clr_reg == (GW+1)'(DEPTH - 1))
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    need_next   = bba_pkg::NEED_W'(req.request_bytes)
                                + bba_pkg::NEED_W'(HEADER_BYTES);
                    want_next   = bba_pkg::WANT_W'(bba_pkg::MIN_ORDER);
                    fstart_next = 17'(req.free_address) - 17'(HEADER_BYTES);
                    if (req.op == bba_pkg::OP_FREE)
                    begin
                        state_next = bba_pkg::S_FCHK_RD;
                    end
                    else
                    begin
                        state_next = bba_pkg::S_SIZE;
                    end
                end
            end
            bba_pkg::S_SIZE:
            begin
                if ((32'd1 << want_reg) < 32'(need_reg))
                begin
                    want_next = want_reg + bba_pkg::WANT_W'(1);
                end
                else if (32'(want_reg) > 32'(REGION_ORDER))
                begin
                    pst_next   = bba_pkg::ST_TOO_BIG;
                    paddr_next = '0;
                    pord_next  = '0;
                    state_next = bba_pkg::S_DONE;
                end
                else
                begin
                    cur_next    = '0;
                    region_next = '0;
                    state_next  = bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_SCAN_RD:
            begin
                if (cur_reg <= stop)
                begin
                    state_next = bba_pkg::S_SCAN_EV;
                end
                else if (region_reg == RW'(REGIONS - 1))
                begin
                    pst_next   = bba_pkg::ST_NO_SPACE;
                    paddr_next = '0;
                    pord_next  = '0;
                    state_next = bba_pkg::S_DONE;
                end
                else
                begin
                    region_next = region_reg + RW'(1);
                    cur_next    = PW'(region_reg + RW'(1)) << REGION_ORDER;
                end
            end
            bba_pkg::S_SCAN_EV:
            begin
                if (32'(ho) < 32'(want_reg))
                begin
                    cur_next   = cur_reg + size;
                    state_next = bba_pkg::S_SCAN_RD;
                end
                else if (hused)
                begin
                    cur_next   = cur_reg + (PW'(1) << ho);
                    state_next = bba_pkg::S_SCAN_RD;
                end
                else
                begin
                    ord_next = ho;
                    if (32'(ho) > 32'(want_reg))
                    begin
                        state_next = bba_pkg::S_SPLIT;
                    end
                    else
                    begin
                        state_next = bba_pkg::S_TAKE;
                    end
                end
            end
            bba_pkg::S_SPLIT:
            begin
                // The upper half of the block becomes a free buddy one order lower.
                we       = 1'b1;
                waddr    = split_at[AW-1:bba_pkg::MIN_ORDER];
                wdata    = {1'b0, o_dec};
                ord_next = o_dec;
                if (32'(o_dec) == 32'(want_reg))
                begin
                    state_next = bba_pkg::S_TAKE;
                end
            end
            bba_pkg::S_TAKE:
            begin
                we         = 1'b1;
                wdata      = {1'b1, ord_reg};
                pst_next   = bba_pkg::ST_OK;
                paddr_next = asum[15:0];
                pord_next  = 4'(want_reg);
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_FCHK_RD:
            begin
                raddr    = fstart32[AW-1:bba_pkg::MIN_ORDER];
                cur_next = fstart32[PW-1:0];
                if (fstart_reg[16] || (fstart_reg[2:0] != 3'd0) || (fstart32 >= ARENA))
                begin
                    pst_next   = bba_pkg::ST_BAD_FREE;
                    paddr_next = '0;
                    pord_next  = '0;
                    state_next = bba_pkg::S_DONE;
                end
                else
                begin
                    state_next = bba_pkg::S_FCHK_EV;
                end
            end
            bba_pkg::S_FCHK_EV:
            begin
                paddr_next = '0;
                if (!hused)
                begin
                    pst_next   = bba_pkg::ST_BAD_FREE;
                    pord_next  = '0;
                    state_next = bba_pkg::S_DONE;
                end
                else
                begin
                    we        = 1'b1;
                    wdata     = {1'b0, ho};
                    ord_next  = ho;
                    pst_next  = bba_pkg::ST_OK;
                    pord_next = 4'(ho);
                    if (32'(ho) < 32'(REGION_ORDER))
                    begin
                        state_next = bba_pkg::S_MRG_RD;
                    end
                    else
                    begin
                        state_next = bba_pkg::S_DONE;
                    end
                end
            end
            bba_pkg::S_MRG_RD:
            begin
                raddr      = bud[AW-1:bba_pkg::MIN_ORDER];
                state_next = bba_pkg::S_MRG_EV;
            end
            bba_pkg::S_MRG_EV:
            begin
                if (hused || (ho != ord_reg))
                begin
                    state_next = bba_pkg::S_DONE;
                end
                else
                begin
                    // The merged block starts at the lower of the two buddies.
                    we       = 1'b1;
                    waddr    = mrg_base[AW-1:bba_pkg::MIN_ORDER];
                    wdata    = {1'b0, ord_reg + OW'(1)};
                    cur_next = mrg_base;
                    ord_next = ord_reg + OW'(1);
                    if (32'(ord_reg) + 32'd1 < 32'(REGION_ORDER))
                    begin
                        state_next = bba_pkg::S_MRG_RD;
                    end
                    else
                    begin
                        state_next = bba_pkg::S_DONE;
                    end
                end
            end
            bba_pkg::S_DONE:
            begin
                if (!rvalid_reg || rsp.ready)
                begin
                    rvalid_next = 1'b1;
                    rst_next    = pst_reg;
                    raddr_next  = paddr_reg;
                    rord_next   = pord_reg;
                    state_next  = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != bba_pkg::ST_OK) |-> (rsp.address == 16'd0)
            && (rsp.block_order == 4'd0))
        else $error("error result carries a non-zero address or order");

    a_scan_size_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::S_SCAN_EV) |-> (32'(want_reg) <= 32'(REGION_ORDER)))
        else $error("scan running with an order above the region order");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::S_IDLE) |-> !we)
        else $error("header write while idle");

    a_split_above_want: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::S_SPLIT) |-> (32'(ord_reg) > 32'(want_reg)))
        else $error("split below the wanted order");

endmodule
`default_nettype wire
